// ===== hw/rtl/vcsd_pkg.sv =====
// Package for the voxel column span decoder.
// Holds the phase codes, result kinds and the state and result structs.
// No dependencies.
package vcsd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PhaseW  = 3;
  localparam int unsigned ZW      = 9;
  localparam int unsigned HeightW = 10;

  // Decoder phase codes.
  localparam logic [PhaseW-1:0] PH_SKIP   = 3'd0;
  localparam logic [PhaseW-1:0] PH_RUN    = 3'd1;
  localparam logic [PhaseW-1:0] PH_COLOR  = 3'd2;
  localparam logic [PhaseW-1:0] PH_NORMAL = 3'd3;
  localparam logic [PhaseW-1:0] PH_TRAIL  = 3'd4;
  localparam logic [PhaseW-1:0] PH_DONE   = 3'd5;

  // Result kinds.
  localparam logic KIND_VERTEX     = 1'b0;
  localparam logic KIND_COLUMN_END = 1'b1;

  typedef struct packed {
    logic [PhaseW-1:0]         phase;
    logic [ZW-1:0]             z_pos;
    logic signed [HeightW-1:0] height_left;
    logic [ByteW-1:0]          run_left;
    logic [ByteW-1:0]          held_color;
    logic [ByteW-1:0]          cur_x;
    logic [ByteW-1:0]          cur_y;
  } vcsd_state_t;

  typedef struct packed {
    logic             kind;
    logic [ByteW-1:0] vert_x;
    logic [ByteW-1:0] vert_y;
    logic [ByteW-1:0] vert_z;
    logic [ByteW-1:0] vert_color;
    logic [ByteW-1:0] vert_normal;
  } vcsd_result_t;

endpackage

// ===== hw/rtl/vcsd_step.sv =====
// Combinational next-state and result logic for one column data byte.
// Depends on vcsd_pkg.
module vcsd_step (
  input  vcsd_pkg::vcsd_state_t  cur,
  input  logic [7:0]             data_byte,
  input  logic                   column_start,
  input  logic [7:0]             column_x,
  input  logic [7:0]             column_y,
  input  logic [7:0]             column_height,
  output vcsd_pkg::vcsd_state_t  nxt,
  output logic                   emit,
  output vcsd_pkg::vcsd_result_t res
);
  import vcsd_pkg::*;

  vcsd_state_t             pre;
  logic [ByteW-1:0]        run_dec;
  logic signed [HeightW-1:0] hl_dec;
  logic                    pre_nonpos;
  logic                    dec_nonpos;
  logic                    start_empty;

  assign start_empty = column_start && (column_height == '0);
  assign run_dec     = pre.run_left - 8'd1;
  assign hl_dec      = pre.height_left - 10'sd1;
  assign pre_nonpos  = pre.height_left[HeightW-1] || (pre.height_left == '0);
  assign dec_nonpos  = hl_dec[HeightW-1] || (hl_dec == '0);

  // A new column reloads position and height before the byte is decoded.
  always_comb begin
    pre = cur;
    if (column_start) begin
      pre.cur_x       = column_x;
      pre.cur_y       = column_y;
      pre.z_pos       = '0;
      pre.run_left    = '0;
      pre.held_color  = '0;
      pre.height_left = $signed({2'b00, column_height});
      pre.phase       = (column_height == '0) ? PH_DONE : PH_SKIP;
    end
  end

  always_comb begin
    nxt             = pre;
    emit            = 1'b0;
    res.kind        = KIND_VERTEX;
    res.vert_x      = pre.cur_x;
    res.vert_y      = pre.cur_y;
    res.vert_z      = pre.z_pos[ByteW-1:0];
    res.vert_color  = '0;
    res.vert_normal = '0;
    if (start_empty) begin
      emit     = 1'b1;
      res.kind = KIND_COLUMN_END;
    end else begin
      unique case (pre.phase)
        PH_SKIP: begin
          nxt.z_pos       = pre.z_pos + {1'b0, data_byte};
          nxt.height_left = pre.height_left - $signed({2'b00, data_byte});
          nxt.phase       = PH_RUN;
        end
        PH_RUN: begin
          nxt.run_left = data_byte;
          nxt.phase    = ((data_byte == '0) || pre_nonpos) ? PH_TRAIL : PH_COLOR;
        end
        PH_COLOR: begin
          nxt.held_color = data_byte;
          nxt.phase      = PH_NORMAL;
        end
        PH_NORMAL: begin
          emit            = 1'b1;
          res.vert_color  = pre.held_color;
          res.vert_normal = data_byte;
          nxt.z_pos       = pre.z_pos + 9'd1;
          nxt.height_left = hl_dec;
          nxt.run_left    = run_dec;
          nxt.phase       = ((run_dec == '0) || dec_nonpos) ? PH_TRAIL : PH_COLOR;
        end
        PH_TRAIL: begin
          if (pre_nonpos) begin
            emit      = 1'b1;
            res.kind  = KIND_COLUMN_END;
            nxt.phase = PH_DONE;
          end else begin
            nxt.phase = PH_SKIP;
          end
        end
        default: begin
          nxt = pre;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/vcsd_out_stage.sv =====
// Single-entry result register with valid/ready handshake toward the consumer.
// Depends on vcsd_pkg.
module vcsd_out_stage (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  vcsd_pkg::vcsd_result_t load_res,
  output logic                   can_load,
  output logic                   out_valid,
  input  logic                   out_ready,
  output vcsd_pkg::vcsd_result_t out_res
);
  import vcsd_pkg::*;

  logic out_valid_next;

  // The slot is free when empty or when its request leaves this cycle.
  assign can_load = !out_valid || out_ready;

  always_comb begin
    priority if (load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= load_res;
    end
  end

endmodule

// ===== hw/rtl/voxel_column_span_decoder.sv =====
// Top level of the voxel column span decoder.
// Depends on vcsd_pkg, vcsd_step and vcsd_out_stage.
//
// The decoder takes one byte of span-encoded voxel column data per request and
// turns every normal byte into a vertex request carrying x, y, z, color and
// normal, plus a column-end request after the last trailer of a column. It
// accepts one byte every clock cycle: the decode of a byte is a short piece of
// logic between the decoder state registers and a one-entry result register,
// and the input is held off only while that result register holds a request
// the consumer has not yet taken. A vertex or column-end request appears on the
// output in the cycle after its byte is accepted. column_height is written
// through column_height_we and column_height_wdata and should only be changed
// while the decoder is idle; a new column latches it on its first byte.
module voxel_column_span_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       column_height_we,
  input  logic [7:0] column_height_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       column_start,
  input  logic [7:0] column_x,
  input  logic [7:0] column_y,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] vert_x,
  output logic [7:0] vert_y,
  output logic [7:0] vert_z,
  output logic [7:0] vert_color,
  output logic [7:0] vert_normal
);
  import vcsd_pkg::*;

  logic [ByteW-1:0] column_height;
  vcsd_state_t      state;
  vcsd_state_t      state_next;
  logic             emit;
  vcsd_result_t     step_res;
  vcsd_result_t     out_res;
  logic             in_accept;
  logic             can_load;

  assign in_ready  = can_load;
  assign in_accept = in_valid && in_ready;

  // Configuration register; the reset height is the full 255 slots.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_height <= 8'd255;
    end else if (column_height_we) begin
      column_height <= column_height_wdata;
    end
  end

  // Decode of the current byte against the stored span state.
  vcsd_step u_step (
    .cur           (state),
    .data_byte     (data_byte),
    .column_start  (column_start),
    .column_x      (column_x),
    .column_y      (column_y),
    .column_height (column_height),
    .nxt           (state_next),
    .emit          (emit),
    .res           (step_res)
  );

  // Span state only advances on an accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase       <= PH_SKIP;
      state.z_pos       <= '0;
      state.height_left <= '0;
      state.run_left    <= '0;
      state.held_color  <= '0;
      state.cur_x       <= '0;
      state.cur_y       <= '0;
    end else if (in_accept) begin
      state <= state_next;
    end
  end

  vcsd_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (in_accept && emit),
    .load_res  (step_res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind        = out_res.kind;
  assign vert_x      = out_res.vert_x;
  assign vert_y      = out_res.vert_y;
  assign vert_z      = out_res.vert_z;
  assign vert_color  = out_res.vert_color;
  assign vert_normal = out_res.vert_normal;

  // The phase never leaves the defined codes.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state.phase <= PH_DONE)
    else $error("decoder phase out of range");

  // Remaining height stays within one column's worth either side of zero.
  a_height_range: assert property (@(posedge clk) disable iff (rst)
    (state.height_left <= 10'sd255) && (state.height_left >= -10'sd255))
    else $error("remaining height out of range");

  // A stalled result blocks new bytes so it cannot be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input accepted while result stalled");

  // Column-end requests carry no color or normal.
  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_COLUMN_END)) |-> ((vert_color == '0) && (vert_normal == '0)))
    else $error("column end carries color or normal");

endmodule
